@@ sv/wsd_pkg.sv @@
`default_nettype none
package wsd_pkg;

	// Header field masks and length codes.
	localparam logic [7:0] FinMask    = 8'h80;
	localparam logic [7:0] MaskFlag   = 8'h80;
	localparam logic [3:0] OpContinue = 4'd0;
	localparam logic [3:0] OpText     = 4'd1;
	localparam logic [3:0] OpClose    = 4'd8;
	localparam logic [6:0] LenCode16  = 7'd126;
	localparam logic [6:0] LenCode64  = 7'd127;
	localparam logic [3:0] ExtBytes16 = 4'd2;
	localparam logic [3:0] ExtBytes64 = 4'd8;

	// Event kinds on the result channel.
	localparam logic EvPayload = 1'b0;
	localparam logic EvClose   = 1'b1;

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HDR1 = 3'd0,
		PH_HDR2 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	// One result of a parse step.
	typedef struct packed {
		logic       has_result;
		logic       event_kind;
		logic [7:0] payload_byte;
		logic       frame_last;
		logic       message_final;
	} result_t;

endpackage
`default_nettype wire

@@ sv/websocket_frame_deframer.sv @@
// WebSocket frame deframer, receive side. One received byte is taken per item on the
// byte_valid/byte_ready channel, and the block accepts one byte every clock while the result
// side keeps up. Each byte passes an input register, the header/payload parse logic, and a
// result register, and its result is presented from the result register. Header,
// length and mask key bytes give no result; text and continuation payload bytes come out
// unmasked with frame_last and message_final marks; other frames are consumed silently. A
// close frame gives one close event on its first header byte, and every later byte is
// accepted and ignored until reset. Only the low 32 bits of a 64-bit extended length are kept.
`default_nettype none
module websocket_frame_deframer (
	input  wire  logic       clk,
	input  wire  logic       arst_n,
	input  wire  logic       byte_valid,
	output logic             byte_ready,
	input  wire  logic [7:0] rx_byte,
	output logic             event_valid,
	input  wire  logic       event_ready,
	output logic             event_kind,
	output logic [7:0]       payload_byte,
	output logic             frame_last,
	output logic             message_final
);
	import wsd_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	result_t    res;
	logic       can_load;
	logic       consume;

	// The staged byte leaves when it gives no result or the result register has room.
	assign consume    = valid_s1 && (!res.has_result || can_load);
	assign byte_ready = !valid_s1 || consume;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	wsd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (consume),
		.rx_byte_s1 (rx_byte_s1),
		.res        (res)
	);

	wsd_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (consume && res.has_result),
		.res           (res),
		.can_load      (can_load),
		.event_valid   (event_valid),
		.event_ready   (event_ready),
		.event_kind    (event_kind),
		.payload_byte  (payload_byte),
		.frame_last    (frame_last),
		.message_final (message_final)
	);

endmodule
`default_nettype wire

@@ sv/wsd_parser.sv @@
`default_nettype none
module wsd_parser (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic step_en,
	input  wire                logic [7:0] rx_byte_s1,
	output wsd_pkg::result_t   res
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_d;
	logic [3:0]  ext_len_count_q, ext_len_count_d;
	logic [31:0] remaining_len_q, remaining_len_d;
	logic [31:0] mask_key_q, mask_key_d;
	logic [1:0]  mask_index_q, mask_index_d;
	logic        frame_fin_q, frame_fin_d;
	logic        frame_masked_q, frame_masked_d;
	logic        frame_deliver_q, frame_deliver_d;
	logic        closed_q, closed_d;

	logic [6:0]  len7;
	logic [3:0]  opcode;
	logic [3:0]  ext_next;
	logic [31:0] rem_dec;
	logic [7:0]  key_byte;
	phase_t      after_hdr;

	// Key byte for the current payload position, first key byte first.
	always_comb begin
		case (mask_index_q)
			2'd0:    key_byte = mask_key_q[31:24];
			2'd1:    key_byte = mask_key_q[23:16];
			2'd2:    key_byte = mask_key_q[15:8];
			default: key_byte = mask_key_q[7:0];
		endcase
	end

	assign len7     = rx_byte_s1[6:0];
	assign opcode   = rx_byte_s1[3:0];
	assign ext_next = ext_len_count_q - 4'd1;
	assign rem_dec  = remaining_len_q - 32'd1;

	// Next-state and result logic for one received byte.
	always_comb begin
		phase_d         = phase_q;
		ext_len_count_d = ext_len_count_q;
		remaining_len_d = remaining_len_q;
		mask_key_d      = mask_key_q;
		mask_index_d    = mask_index_q;
		frame_fin_d     = frame_fin_q;
		frame_masked_d  = frame_masked_q;
		frame_deliver_d = frame_deliver_q;
		closed_d        = closed_q;
		after_hdr       = PH_HDR1;
		res             = '0;
		if (!closed_q) begin
			case (phase_q)
				PH_HDR2: begin
					frame_masked_d  = rx_byte_s1[7];
					remaining_len_d = '0;
					if (len7 == LenCode16) begin
						ext_len_count_d = ExtBytes16;
						phase_d         = PH_EXT;
					end else if (len7 == LenCode64) begin
						ext_len_count_d = ExtBytes64;
						phase_d         = PH_EXT;
					end else begin
						ext_len_count_d = '0;
						remaining_len_d = {25'd0, len7};
						after_hdr = (len7 == 7'd0) ? PH_HDR1 : PH_DATA;
						if (rx_byte_s1[7]) begin
							mask_index_d = '0;
							phase_d      = PH_KEY;
						end else begin
							phase_d = after_hdr;
						end
					end
				end
				PH_EXT: begin
					remaining_len_d = {remaining_len_q[23:0], rx_byte_s1};
					ext_len_count_d = ext_next;
					if (ext_next == 4'd0) begin
						after_hdr = (remaining_len_d == 32'd0) ? PH_HDR1 : PH_DATA;
						if (frame_masked_q) begin
							mask_index_d = '0;
							phase_d      = PH_KEY;
						end else begin
							phase_d = after_hdr;
						end
					end
				end
				PH_KEY: begin
					mask_key_d = {mask_key_q[23:0], rx_byte_s1};
					if (mask_index_q == 2'd3) begin
						mask_index_d = '0;
						phase_d = (remaining_len_q == 32'd0) ? PH_HDR1 : PH_DATA;
					end else begin
						mask_index_d = mask_index_q + 2'd1;
					end
				end
				PH_DATA: begin
					mask_index_d    = mask_index_q + 2'd1;
					remaining_len_d = rem_dec;
					if (rem_dec == 32'd0) begin
						phase_d = PH_HDR1;
					end
					res.has_result    = frame_deliver_q;
					res.event_kind    = EvPayload;
					res.payload_byte  = rx_byte_s1 ^ (frame_masked_q ? key_byte : 8'd0);
					res.frame_last    = (rem_dec == 32'd0);
					res.message_final = frame_fin_q;
				end
				default: begin
					frame_fin_d     = |(rx_byte_s1 & FinMask);
					frame_deliver_d = (opcode == OpContinue) || (opcode == OpText);
					phase_d         = PH_HDR2;
					if (opcode == OpClose) begin
						closed_d          = 1'b1;
						res.has_result    = 1'b1;
						res.event_kind    = EvClose;
						res.message_final = 1'b1;
					end
				end
			endcase
		end
	end

	// State registers advance only when the item is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HDR1;
			ext_len_count_q <= '0;
			remaining_len_q <= '0;
			mask_key_q      <= '0;
			mask_index_q    <= '0;
			frame_fin_q     <= 1'b0;
			frame_masked_q  <= 1'b0;
			frame_deliver_q <= 1'b0;
			closed_q        <= 1'b0;
		end else if (step_en) begin
			phase_q         <= phase_d;
			ext_len_count_q <= ext_len_count_d;
			remaining_len_q <= remaining_len_d;
			mask_key_q      <= mask_key_d;
			mask_index_q    <= mask_index_d;
			frame_fin_q     <= frame_fin_d;
			frame_masked_q  <= frame_masked_d;
			frame_deliver_q <= frame_deliver_d;
			closed_q        <= closed_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/wsd_out_reg.sv @@
`default_nettype none
module wsd_out_reg (
	input  wire              logic clk,
	input  wire              logic arst_n,
	input  wire              logic load,
	input  wire              wsd_pkg::result_t res,
	output logic             can_load,
	output logic             event_valid,
	input  wire              logic event_ready,
	output logic             event_kind,
	output logic [7:0]       payload_byte,
	output logic             frame_last,
	output logic             message_final
);
	import wsd_pkg::*;

	logic       valid_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       final_q;

	// The register takes a new result when empty or when its item leaves.
	assign can_load = !valid_q || event_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			kind_q  <= res.event_kind;
			byte_q  <= res.payload_byte;
			last_q  <= res.frame_last;
			final_q <= res.message_final;
		end
	end

	assign event_valid   = valid_q;
	assign event_kind    = kind_q;
	assign payload_byte  = byte_q;
	assign frame_last    = last_q;
	assign message_final = final_q;

endmodule
`default_nettype wire

@@ sv/wsd_checker.sv @@
`default_nettype none
module wsd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       byte_valid,
	input wire logic       byte_ready,
	input wire logic       event_valid,
	input wire logic       event_ready,
	input wire logic       event_kind,
	input wire logic [7:0] payload_byte,
	input wire logic       frame_last,
	input wire logic       message_final
);
	import wsd_pkg::*;

	// A stalled result holds its item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && !event_ready |=> event_valid && $stable(event_kind)
		&& $stable(payload_byte) && $stable(frame_last) && $stable(message_final))
		else $error("result changed while stalled");

	// A close event carries a zero byte, no frame end mark and a set final mark.
	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_kind == EvClose |->
		payload_byte == 8'd0 && !frame_last && message_final)
		else $error("close event fields wrong");

	// Nothing follows a delivered close event.
	a_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid && event_ready && event_kind == EvClose |=> !event_valid)
		else $error("result after close event");

	// No result can appear unless a byte was offered on byte_valid earlier, accepted or
	// not, or a result was already waiting.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(event_valid) |-> $past(byte_valid && byte_ready, 2) || $past(event_valid, 1)
		|| $past(byte_valid, 2))
		else $error("result without a byte");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
`default_nettype wire
